/* hw/rtl/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the LED blink controller: command kinds,
// blink modes, field widths and the word passed from timing to LED bank.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int KIND_W   = 2;
    localparam int LED_W    = 2;
    localparam int COUNT_W  = 7;
    localparam int DUTY_W   = 7;
    localparam int PERIOD_W = 16;
    localparam int STEP_W   = 8;
    localparam int TOGGLE_W = 8;
    localparam int PINS_W   = 4;

    localparam int PRODUCT_W = PERIOD_W + DUTY_W;

    // duty is a percentage, anything above full scale is clipped
    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

    // divide by 100 as multiply by ceil(2^30/100), exact for all products
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    localparam logic [STEP_W-1:0] TICK_STEP_RESET = 8'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_ON    = 2'd2,
        KIND_OFF   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'b001,
        MODE_LIMITED   = 3'b010,
        MODE_UNLIMITED = 3'b100
    } mode_t;

    typedef struct packed {
        kind_t               kind;
        logic [LED_W-1:0]    led;
        logic [COUNT_W-1:0]  count;
        logic [PERIOD_W-1:0] on_time;
        logic [PERIOD_W-1:0] off_time;
    } update_t;

endpackage

/* hw/rtl/lbc_cmd_if.sv */
// ----------------------------------------------------------------------------
// lbc_cmd_if
// Command channel: tick, start blink, force on and force off words.
// ----------------------------------------------------------------------------
interface lbc_cmd_if;

    logic                          valid;
    logic                          ready;
    logic [lbc_pkg::KIND_W-1:0]    kind;
    logic [lbc_pkg::LED_W-1:0]     led;
    logic [lbc_pkg::COUNT_W-1:0]   blinks;
    logic [lbc_pkg::DUTY_W-1:0]    duty_percent;
    logic [lbc_pkg::PERIOD_W-1:0]  period_ms;

    modport source (
        output valid, kind, led, blinks, duty_percent, period_ms,
        input  ready
    );

    modport sink (
        input  valid, kind, led, blinks, duty_percent, period_ms,
        output ready
    );

endinterface

/* hw/rtl/lbc_res_if.sv */
// ----------------------------------------------------------------------------
// lbc_res_if
// Result channel: LED drive levels and blinking mask after each command.
// ----------------------------------------------------------------------------
interface lbc_res_if;

    logic                        valid;
    logic                        ready;
    logic [lbc_pkg::PINS_W-1:0]  led_pins;
    logic [lbc_pkg::PINS_W-1:0]  active_mask;

    modport source (
        output valid, led_pins, active_mask,
        input  ready
    );

    modport sink (
        input  valid, led_pins, active_mask,
        output ready
    );

endinterface

/* hw/rtl/lbc_timing.sv */
// ----------------------------------------------------------------------------
// lbc_timing
// Input register and on/off time computation: period * duty in one stage,
// divide by 100 through a reciprocal multiply in the next.
// ----------------------------------------------------------------------------
module lbc_timing (
    input  logic             clk,
    input  logic             rst_n,
    lbc_cmd_if.sink          cmd,
    output logic             upd_valid,
    input  logic             upd_ready,
    output lbc_pkg::update_t upd_word
);

    localparam int SCALED_W = lbc_pkg::PRODUCT_W + lbc_pkg::RECIP_W;

    // stage 1: input register
    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic [lbc_pkg::KIND_W-1:0]     s1_kind_reg;
    logic [lbc_pkg::LED_W-1:0]      s1_led_reg;
    logic [lbc_pkg::COUNT_W-1:0]    s1_count_reg;
    logic [lbc_pkg::DUTY_W-1:0]     s1_duty_reg;
    logic [lbc_pkg::PERIOD_W-1:0]   s1_period_reg;

    // stage 2: product register
    logic                           s2_valid_reg;
    logic                           s2_valid_next;
    logic [lbc_pkg::KIND_W-1:0]     s2_kind_reg;
    logic [lbc_pkg::LED_W-1:0]      s2_led_reg;
    logic [lbc_pkg::COUNT_W-1:0]    s2_count_reg;
    logic [lbc_pkg::PERIOD_W-1:0]   s2_period_reg;
    logic [lbc_pkg::PRODUCT_W-1:0]  s2_product_reg;
    logic [lbc_pkg::PRODUCT_W-1:0]  s2_product_next;

    // stage 3: timing word register
    logic                           s3_valid_reg;
    logic                           s3_valid_next;
    lbc_pkg::update_t               s3_word_reg;
    lbc_pkg::update_t               s3_word_next;

    logic                           s1_ready;
    logic                           s2_ready;
    logic                           s3_ready;
    logic                           s1_load;
    logic                           s2_load;
    logic                           s3_load;
    logic [lbc_pkg::DUTY_W-1:0]     duty_clip;
    logic [SCALED_W-1:0]            scaled;
    logic [lbc_pkg::PERIOD_W-1:0]   on_time;

    assign s3_ready = !s3_valid_reg || upd_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign cmd.ready = s1_ready;
    assign s1_load   = cmd.valid && s1_ready;
    assign s2_load   = s1_valid_reg && s2_ready;
    assign s3_load   = s2_valid_reg && s3_ready;

    assign s1_valid_next = s1_load || (s1_valid_reg && !s2_ready);
    assign s2_valid_next = s2_load || (s2_valid_reg && !s3_ready);
    assign s3_valid_next = s3_load || (s3_valid_reg && !upd_ready);

    always_comb
    begin
        duty_clip = (s1_duty_reg > lbc_pkg::DUTY_FULL) ? lbc_pkg::DUTY_FULL : s1_duty_reg;
        s2_product_next = lbc_pkg::PRODUCT_W'(s1_period_reg)
                        * lbc_pkg::PRODUCT_W'(duty_clip);
    end

    always_comb
    begin
        scaled  = SCALED_W'(s2_product_reg) * SCALED_W'(lbc_pkg::RECIP_100);
        on_time = scaled[lbc_pkg::RECIP_SHIFT +: lbc_pkg::PERIOD_W];
        s3_word_next.kind     = lbc_pkg::kind_t'(s2_kind_reg);
        s3_word_next.led      = s2_led_reg;
        s3_word_next.count    = s2_count_reg;
        s3_word_next.on_time  = on_time;
        s3_word_next.off_time = s2_period_reg - on_time;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_kind_reg   <= cmd.kind;
            s1_led_reg    <= cmd.led;
            s1_count_reg  <= cmd.blinks;
            s1_duty_reg   <= cmd.duty_percent;
            s1_period_reg <= cmd.period_ms;
        end
        if (s2_load)
        begin
            s2_kind_reg    <= s1_kind_reg;
            s2_led_reg     <= s1_led_reg;
            s2_count_reg   <= s1_count_reg;
            s2_period_reg  <= s1_period_reg;
            s2_product_reg <= s2_product_next;
        end
        if (s3_load)
        begin
            s3_word_reg <= s3_word_next;
        end
    end

    assign upd_valid = s3_valid_reg;
    assign upd_word  = s3_word_reg;

endmodule

/* hw/rtl/lbc_led_bank.sv */
// ----------------------------------------------------------------------------
// lbc_led_bank
// Per-LED blink state, the tick step register and the result register.
// A tick word updates every LED in the cycle it is accepted, others one LED.
// ----------------------------------------------------------------------------
module lbc_led_bank #(
    parameter int LED_COUNT = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lbc_pkg::STEP_W-1:0]  cfg_wr_data,
    input  logic                        upd_valid,
    output logic                        upd_ready,
    input  lbc_pkg::update_t            upd_word,
    lbc_res_if.source                   res
);

    localparam int SHOWN = (LED_COUNT < lbc_pkg::PINS_W) ? LED_COUNT : lbc_pkg::PINS_W;

    logic [lbc_pkg::STEP_W-1:0]    tick_step_reg;

    lbc_pkg::mode_t                mode_reg     [LED_COUNT];
    lbc_pkg::mode_t                mode_next    [LED_COUNT];
    logic                          level_reg    [LED_COUNT];
    logic                          level_next   [LED_COUNT];
    logic                          status_reg   [LED_COUNT];
    logic                          status_next  [LED_COUNT];
    logic [lbc_pkg::TOGGLE_W-1:0]  toggles_reg  [LED_COUNT];
    logic [lbc_pkg::TOGGLE_W-1:0]  toggles_next [LED_COUNT];
    logic [lbc_pkg::PERIOD_W-1:0]  time_reg     [LED_COUNT];
    logic [lbc_pkg::PERIOD_W-1:0]  time_next    [LED_COUNT];
    logic [lbc_pkg::PERIOD_W-1:0]  on_reg       [LED_COUNT];
    logic [lbc_pkg::PERIOD_W-1:0]  on_next      [LED_COUNT];
    logic [lbc_pkg::PERIOD_W-1:0]  off_reg      [LED_COUNT];
    logic [lbc_pkg::PERIOD_W-1:0]  off_next     [LED_COUNT];

    logic                          res_valid_reg;
    logic                          res_valid_next;
    logic [lbc_pkg::PINS_W-1:0]    pins_reg;
    logic [lbc_pkg::PINS_W-1:0]    pins_next;
    logic [lbc_pkg::PINS_W-1:0]    active_reg;
    logic [lbc_pkg::PINS_W-1:0]    active_next;

    logic                          fire;
    logic [lbc_pkg::PERIOD_W-1:0]  step_wide;

    assign upd_ready      = !res_valid_reg || res.ready;
    assign fire           = upd_valid && upd_ready;
    assign res_valid_next = fire || (res_valid_reg && !res.ready);
    assign step_wide      = lbc_pkg::PERIOD_W'(tick_step_reg);

    always_comb
    begin
        logic advance;
        logic hit;
        advance = 1'b0;
        hit     = 1'b0;
        for (int i = 0; i < LED_COUNT; i++)
        begin
            mode_next[i]    = mode_reg[i];
            level_next[i]   = level_reg[i];
            status_next[i]  = status_reg[i];
            toggles_next[i] = toggles_reg[i];
            time_next[i]    = time_reg[i];
            on_next[i]      = on_reg[i];
            off_next[i]     = off_reg[i];
            advance         = 1'b0;
            hit             = (int'(upd_word.led) == i);

            if (fire)
            begin
                case (upd_word.kind)
                    lbc_pkg::KIND_TICK:
                    begin
                        case (mode_reg[i])
                            lbc_pkg::MODE_LIMITED:
                            begin
                                if (toggles_reg[i] != '0)
                                begin
                                    advance = 1'b1;
                                end
                                else
                                begin
                                    // budget spent: force off and stop
                                    level_next[i]  = 1'b0;
                                    status_next[i] = 1'b0;
                                    mode_next[i]   = lbc_pkg::MODE_IDLE;
                                end
                            end
                            lbc_pkg::MODE_UNLIMITED:
                            begin
                                advance = 1'b1;
                            end
                            default:
                            begin
                                advance = 1'b0;
                            end
                        endcase

                        if (advance)
                        begin
                            if (time_reg[i] != '0)
                            begin
                                time_next[i] = (time_reg[i] >= step_wide) ?
                                               time_reg[i] - step_wide : '0;
                            end
                            else
                            begin
                                // toggle direction follows recorded status
                                if (status_reg[i])
                                begin
                                    time_next[i]   = off_reg[i];
                                    level_next[i]  = 1'b0;
                                    status_next[i] = 1'b0;
                                end
                                else
                                begin
                                    time_next[i]   = on_reg[i];
                                    level_next[i]  = 1'b1;
                                    status_next[i] = 1'b1;
                                end
                                if (mode_reg[i] == lbc_pkg::MODE_LIMITED)
                                begin
                                    toggles_next[i] = toggles_reg[i]
                                                    - lbc_pkg::TOGGLE_W'(1);
                                end
                            end
                        end
                    end
                    lbc_pkg::KIND_START:
                    begin
                        if (hit)
                        begin
                            toggles_next[i] = {upd_word.count, 1'b0};
                            on_next[i]      = upd_word.on_time;
                            off_next[i]     = upd_word.off_time;
                            mode_next[i]    = (upd_word.count == '0) ?
                                              lbc_pkg::MODE_UNLIMITED :
                                              lbc_pkg::MODE_LIMITED;
                        end
                    end
                    lbc_pkg::KIND_ON:
                    begin
                        if (hit)
                        begin
                            level_next[i]  = 1'b1;
                            status_next[i] = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (hit)
                        begin
                            level_next[i]  = 1'b0;
                            status_next[i] = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        pins_next   = '0;
        active_next = '0;
        for (int b = 0; b < SHOWN; b++)
        begin
            pins_next[b]   = level_next[b];
            active_next[b] = (mode_next[b] != lbc_pkg::MODE_IDLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_step_reg <= lbc_pkg::TICK_STEP_RESET;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < LED_COUNT; i++)
            begin
                mode_reg[i]    <= lbc_pkg::MODE_IDLE;
                level_reg[i]   <= 1'b1;
                status_reg[i]  <= 1'b0;
                toggles_reg[i] <= '0;
                time_reg[i]    <= '0;
                on_reg[i]      <= '0;
                off_reg[i]     <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tick_step_reg <= cfg_wr_data;
            end
            res_valid_reg <= res_valid_next;
            for (int i = 0; i < LED_COUNT; i++)
            begin
                mode_reg[i]    <= mode_next[i];
                level_reg[i]   <= level_next[i];
                status_reg[i]  <= status_next[i];
                toggles_reg[i] <= toggles_next[i];
                time_reg[i]    <= time_next[i];
                on_reg[i]      <= on_next[i];
                off_reg[i]     <= off_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pins_reg   <= pins_next;
            active_reg <= active_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.led_pins    = pins_reg;
    assign res.active_mask = active_reg;

endmodule

/* hw/rtl/led_blink_controller.sv */
// a word passes the input, product, timing word and result registers in order
// throughput: one word per cycle while results are taken; all LED timers
// update in the same cycle; on/off split: one multiply, one reciprocal stage
// reset: every LED idle, driven on and recorded as off, timers cleared,
// tick_step 10, no words in flight
// ----------------------------------------------------------------------------
// led_blink_controller
// Multi-LED blink controller: timing pipeline feeding a per-LED state bank.
// ----------------------------------------------------------------------------
module led_blink_controller #(
    parameter int LED_COUNT = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lbc_pkg::STEP_W-1:0]  cfg_wr_data,
    lbc_cmd_if.sink                     cmd,
    lbc_res_if.source                   res
);

    logic              upd_valid;
    logic              upd_ready;
    lbc_pkg::update_t  upd_word;

    lbc_timing u_timing (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .upd_valid (upd_valid),
        .upd_ready (upd_ready),
        .upd_word  (upd_word)
    );

    lbc_led_bank #(
        .LED_COUNT (LED_COUNT)
    ) u_led_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .upd_valid   (upd_valid),
        .upd_ready   (upd_ready),
        .upd_word    (upd_word),
        .res         (res)
    );

endmodule
